// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clk_i with active-low rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// shared types, codes and bit-scan helpers of the domain constraint filter
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned IdxSpan  = 64;
  localparam int unsigned ValW     = 6;
  localparam int unsigned LimW     = 7;
  localparam int unsigned NumVariablesDef = 64;
  localparam int unsigned DomainValuesDef = 64;

  typedef enum logic [3:0] {
    FN_WRITE = 4'd0,
    FN_READ  = 4'd1,
    FN_LT    = 4'd2,
    FN_LEQ   = 4'd3,
    FN_EQ    = 4'd4,
    FN_NEQ   = 4'd5,
    FN_EQC   = 4'd6,
    FN_NEQC  = 4'd7,
    FN_LTC   = 4'd8,
    FN_LEQC  = 4'd9,
    FN_GTC   = 4'd10,
    FN_GEQC  = 4'd11
  } func_e;

  typedef enum logic [1:0] {
    ST_UNPRUNED = 2'd0,
    ST_PRUNED   = 2'd1,
    ST_FAILURE  = 2'd2
  } status_e;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ValW-1:0]  val_t;

  // operation held for the whole of one item
  typedef struct packed {
    func_e func;
    logic  second;
    val_t  cval;
    logic  tgt_ok;
  } op_t;

  // lowest and highest set value of target and other domain
  typedef struct packed {
    val_t lo_tgt;
    val_t hi_tgt;
    val_t lo_oth;
    val_t hi_oth;
  } bounds_t;

  typedef struct packed {
    status_e status;
    logic    wr;
    word_t   wdata;
    word_t   rdom;
  } prune_res_t;

  // values strictly below lim
  function automatic word_t below_mask(logic [LimW-1:0] lim);
    word_t m;
    if (lim >= LimW'(WordW)) begin
      m = '1;
    end else begin
      m = (word_t'(1) << lim) - word_t'(1);
    end
    return m;
  endfunction

  // lowest set bit, top index for an empty word
  function automatic val_t lowest(word_t d);
    val_t r;
    r = val_t'(WordW - 1);
    for (int i = WordW - 1; i >= 0; i--) begin
      if (d[i]) begin
        r = val_t'(i);
      end
    end
    return r;
  endfunction

  // highest set bit, zero for an empty word
  function automatic val_t highest(word_t d);
    val_t r;
    r = '0;
    for (int i = 0; i < WordW; i++) begin
      if (d[i]) begin
        r = val_t'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/dcf_store.sv =====
// ----------------------------------------------------------------------------
// dcf_store
// domain memory: two registered read ports, one write port, valid bit per entry
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dcf_store #(
  parameter int unsigned NUM_VARIABLES = dcf_pkg::NumVariablesDef,
  parameter int unsigned DOMAIN_VALUES = dcf_pkg::DomainValuesDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    re_i,
  input  wire logic [dcf_pkg::IdxW-1:0] raddr_a_i,
  input  wire logic [dcf_pkg::IdxW-1:0] raddr_b_i,
  input  wire logic                    we_i,
  input  wire logic [dcf_pkg::IdxW-1:0] waddr_i,
  input  wire dcf_pkg::word_t          wdata_i,
  output dcf_pkg::word_t               rdata_a_o,
  output dcf_pkg::word_t               rdata_b_o
);
  import dcf_pkg::*;

  // only 64 indices are reachable
  localparam int unsigned Depth = (NUM_VARIABLES < IdxSpan) ? NUM_VARIABLES : IdxSpan;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam word_t       VMask = below_mask(LimW'(DOMAIN_VALUES));

  word_t            mem_q [Depth];
  logic [Depth-1:0] valid_q;
  word_t            raw_a_q, raw_b_q;
  logic             rv_a_q, rv_b_q;

  logic             ok_a, ok_b, ok_w;
  logic [AddrW-1:0] a_addr, b_addr, w_addr;

  assign ok_a   = {1'b0, raddr_a_i} < LimW'(Depth);
  assign ok_b   = {1'b0, raddr_b_i} < LimW'(Depth);
  assign ok_w   = {1'b0, waddr_i} < LimW'(Depth);
  assign a_addr = raddr_a_i[AddrW-1:0];
  assign b_addr = raddr_b_i[AddrW-1:0];
  assign w_addr = waddr_i[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i && ok_w) begin
      mem_q[w_addr] <= wdata_i & VMask;
    end
    if (re_i) begin
      raw_a_q <= mem_q[a_addr];
      raw_b_q <= mem_q[b_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv_a_q  <= 1'b0;
      rv_b_q  <= 1'b0;
    end else begin
      if (we_i && ok_w) begin
        valid_q[w_addr] <= 1'b1;
      end
      if (re_i) begin
        rv_a_q <= ok_a && valid_q[a_addr];
        rv_b_q <= ok_b && valid_q[b_addr];
      end
    end
  end

  // never-written or out-of-range entries read as empty
  assign rdata_a_o = rv_a_q ? raw_a_q : '0;
  assign rdata_b_o = rv_b_q ? raw_b_q : '0;

  `ASSERT_CLK(a_no_rw_overlap, !(we_i && re_i), "store read and write in the same cycle")
  `ASSERT_ALWAYS(a_valid_clear_in_reset, !rst_ni |=> (valid_q == '0), "valid bits not cleared by reset")
  `ASSERT_CLK(a_waddr_known, we_i |-> !$isunknown(waddr_i), "unknown store write address")

endmodule

`default_nettype wire

// ===== src/dcf_scan.sv =====
// ----------------------------------------------------------------------------
// dcf_scan
// lowest and highest value of the target and the other domain
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_scan (
  input  wire dcf_pkg::word_t dom_tgt_i,
  input  wire dcf_pkg::word_t dom_oth_i,
  output dcf_pkg::bounds_t    bounds_o
);
  import dcf_pkg::*;

  always_comb begin
    bounds_o.lo_tgt = lowest(dom_tgt_i);
    bounds_o.hi_tgt = highest(dom_tgt_i);
    bounds_o.lo_oth = lowest(dom_oth_i);
    bounds_o.hi_oth = highest(dom_oth_i);
  end

endmodule

`default_nettype wire

// ===== src/dcf_prune.sv =====
// ----------------------------------------------------------------------------
// dcf_prune
// applies one filter, write or read to the target domain and decides status and write-back
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_prune #(
  parameter int unsigned DOMAIN_VALUES = dcf_pkg::DomainValuesDef
) (
  input  wire dcf_pkg::op_t     op_i,
  input  wire dcf_pkg::word_t   word_i,
  input  wire dcf_pkg::word_t   dom_tgt_i,
  input  wire dcf_pkg::word_t   dom_oth_i,
  input  wire dcf_pkg::bounds_t bounds_i,
  output dcf_pkg::prune_res_t   res_o
);
  import dcf_pkg::*;

  localparam word_t VMask = below_mask(LimW'(DOMAIN_VALUES));

  typedef struct packed {
    status_e status;
    word_t   nd;
  } keep_t;

  // keep values below lim
  function automatic keep_t keep_below(word_t d, val_t lo, val_t hi, logic [LimW-1:0] lim);
    keep_t k;
    k.nd = d;
    if (d == '0) begin
      k.status = ST_FAILURE;
    end else if ({1'b0, hi} < lim) begin
      k.status = ST_UNPRUNED;
    end else if ({1'b0, lo} >= lim) begin
      k.status = ST_FAILURE;
    end else begin
      k.status = ST_PRUNED;
      k.nd     = d & below_mask(lim);
    end
    return k;
  endfunction

  // keep values at or above lim
  function automatic keep_t keep_atleast(word_t d, val_t lo, val_t hi, logic [LimW-1:0] lim);
    keep_t k;
    k.nd = d;
    if (d == '0) begin
      k.status = ST_FAILURE;
    end else if ({1'b0, lo} >= lim) begin
      k.status = ST_UNPRUNED;
    end else if ({1'b0, hi} < lim) begin
      k.status = ST_FAILURE;
    end else begin
      k.status = ST_PRUNED;
      k.nd     = d & ~below_mask(lim);
    end
    return k;
  endfunction

  word_t            d, o, cmask, rm;
  keep_t            k;
  logic [LimW-1:0]  c7, c7p1, hi_lim, lo_lim;

  always_comb begin
    d      = dom_tgt_i;
    o      = dom_oth_i;
    cmask  = (word_t'(1) << op_i.cval) & VMask;
    c7     = {1'b0, op_i.cval};
    c7p1   = c7 + LimW'(1);
    hi_lim = {1'b0, bounds_i.hi_oth} + ((op_i.func == FN_LEQ) ? LimW'(1) : LimW'(0));
    lo_lim = {1'b0, bounds_i.lo_oth} + ((op_i.func == FN_LT) ? LimW'(1) : LimW'(0));
    rm     = '0;
    k.status = ST_UNPRUNED;
    k.nd     = d;
    res_o.wr    = 1'b0;
    res_o.wdata = word_i;
    res_o.rdom  = d;

    case (op_i.func)
      FN_WRITE: begin
        res_o.wr   = 1'b1;
        res_o.rdom = op_i.tgt_ok ? (word_i & VMask) : '0;
      end
      FN_READ: begin
        res_o.rdom = d;
      end
      FN_LT, FN_LEQ: begin
        if (o == '0) begin
          k.status = ST_FAILURE;
        end else if (!op_i.second) begin
          k = keep_below(d, bounds_i.lo_tgt, bounds_i.hi_tgt, hi_lim);
        end else begin
          k = keep_atleast(d, bounds_i.lo_tgt, bounds_i.hi_tgt, lo_lim);
        end
      end
      FN_EQ: begin
        k.nd = d & o;
        if (k.nd == d) begin
          k.status = ST_UNPRUNED;
        end else if (k.nd == '0) begin
          k.status = ST_FAILURE;
        end else begin
          k.status = ST_PRUNED;
        end
      end
      FN_NEQ, FN_NEQC: begin
        // a singleton other domain removes its one value
        if (op_i.func == FN_NEQ) begin
          rm = $onehot(o) ? o : '0;
        end else begin
          rm = cmask;
        end
        if ((d & rm) != '0) begin
          k.nd     = d & ~rm;
          k.status = (k.nd == '0) ? ST_FAILURE : ST_PRUNED;
        end
      end
      FN_EQC: begin
        if ((d & cmask) == '0) begin
          // failed equality empties the domain
          k.status    = ST_FAILURE;
          res_o.wr    = 1'b1;
          res_o.wdata = '0;
          res_o.rdom  = '0;
        end else if (d != cmask) begin
          k.status = ST_PRUNED;
          k.nd     = cmask;
        end
      end
      FN_LTC:  k = keep_below(d, bounds_i.lo_tgt, bounds_i.hi_tgt, c7);
      FN_LEQC: k = keep_below(d, bounds_i.lo_tgt, bounds_i.hi_tgt, c7p1);
      FN_GTC:  k = keep_atleast(d, bounds_i.lo_tgt, bounds_i.hi_tgt, c7p1);
      FN_GEQC: k = keep_atleast(d, bounds_i.lo_tgt, bounds_i.hi_tgt, c7);
      default: begin
        res_o.rdom = '0;
      end
    endcase

    if (k.status == ST_PRUNED) begin
      res_o.wr    = 1'b1;
      res_o.wdata = k.nd;
      res_o.rdom  = k.nd;
    end
    res_o.status = k.status;
  end

endmodule

`default_nettype wire

// ===== src/domain_constraint_filter.sv =====
// ----------------------------------------------------------------------------
// domain_constraint_filter
// store of variable domains with unary and binary bounds/consistency filters
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid_i / in_ready_o carries one operation per transfer:
//   write or read a domain, or apply a filter to a target domain
//   output channel out_valid_o / out_ready_i returns one status and the
//   target's resulting domain for every input transfer, in order
//   sequence: store read (both domains at once), bound scan, then filter
//   with write-back
//   in_ready_o is high only while no item is in flight; a finished result
//   may still wait on the output register while the next item is taken
//   receiver stall: the filter stage holds, without writing the store,
//   until the output register is free
//   reset: every domain reads as empty at once, through per-entry valid
//   bits, so no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module domain_constraint_filter #(
  parameter int unsigned NUM_VARIABLES = dcf_pkg::NumVariablesDef,
  parameter int unsigned DOMAIN_VALUES = dcf_pkg::DomainValuesDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [3:0]              func_i,
  input  wire logic [dcf_pkg::IdxW-1:0] first_var_i,
  input  wire logic [dcf_pkg::IdxW-1:0] second_var_i,
  input  wire logic                    prune_second_i,
  input  wire logic [dcf_pkg::ValW-1:0] constant_value_i,
  input  wire logic [63:0]             domain_word_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   status_o,
  output logic [63:0]                  result_domain_o
);
  import dcf_pkg::*;

  localparam int unsigned Depth = (NUM_VARIABLES < IdxSpan) ? NUM_VARIABLES : IdxSpan;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  state_e          state_q;
  op_t             op_q, op_d;
  logic [IdxW-1:0] tgt_q;
  word_t           word_q;
  bounds_t         bounds_q, bounds_c;
  logic            out_valid_q;
  status_e         status_q;
  word_t           result_q;

  logic            accept, is_bin, swap, out_free, store_we;
  logic [IdxW-1:0] rd_tgt, rd_oth;
  word_t           dom_tgt, dom_oth;
  prune_res_t      res;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // binary filters may prune the second variable: swap the read ports
  assign is_bin = (func_i >= FN_LT) && (func_i <= FN_NEQ);
  assign swap   = is_bin && prune_second_i;
  assign rd_tgt = swap ? second_var_i : first_var_i;
  assign rd_oth = swap ? first_var_i : second_var_i;

  always_comb begin
    op_d.func   = func_e'(func_i);
    op_d.second = prune_second_i;
    op_d.cval   = constant_value_i;
    op_d.tgt_ok = {1'b0, rd_tgt} < LimW'(Depth);
  end

  // output register is free when empty or when the current result leaves this cycle
  assign out_free = !out_valid_q || out_ready_i;
  assign store_we = (state_q == S_APPLY) && out_free && res.wr;

  dcf_store #(
    .NUM_VARIABLES (NUM_VARIABLES),
    .DOMAIN_VALUES (DOMAIN_VALUES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (accept),
    .raddr_a_i (rd_tgt),
    .raddr_b_i (rd_oth),
    .we_i      (store_we),
    .waddr_i   (tgt_q),
    .wdata_i   (res.wdata),
    .rdata_a_o (dom_tgt),
    .rdata_b_o (dom_oth)
  );

  // read data stays put until the next transfer, so both later stages use it
  dcf_scan u_scan (
    .dom_tgt_i (dom_tgt),
    .dom_oth_i (dom_oth),
    .bounds_o  (bounds_c)
  );

  dcf_prune #(
    .DOMAIN_VALUES (DOMAIN_VALUES)
  ) u_prune (
    .op_i      (op_q),
    .word_i    (word_q),
    .dom_tgt_i (dom_tgt),
    .dom_oth_i (dom_oth),
    .bounds_i  (bounds_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      tgt_q       <= '0;
      word_q      <= '0;
      bounds_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_UNPRUNED;
      result_q    <= '0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if ((state_q == S_APPLY) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= op_d;
            tgt_q   <= rd_tgt;
            word_q  <= domain_word_i;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          bounds_q <= bounds_c;
          state_q  <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            status_q <= res.status;
            result_q <= res.rdom;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_domain_o = result_q;

  `ASSERT_CLK(a_result_from_apply, $rose(out_valid_q) |-> $past(state_q == S_APPLY), "result without filter stage")
  `ASSERT_CLK(a_no_write_on_stall, store_we |-> (!out_valid_q || out_ready_i), "store written while output stalled")
  `ASSERT_CLK(a_accept_starts_eval, accept |=> (state_q == S_EVAL), "transfer did not start the scan")

endmodule

`default_nettype wire
